>>> hdl/button_gesture_classifier_top_defines.svh
// assertion macros for the button gesture classifier
// expects clk_i and rst_ni in the module that uses them
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BGC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BGC_ASSERT(lbl, prop, msg)
`define BGC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/bgc_pkg.sv
// shared types and constants of the button gesture classifier
// no dependencies
package bgc_pkg;

  localparam int unsigned BrightnessRangeDef = 255;
  localparam int unsigned QuadClicksDef      = 4;

  localparam logic [15:0] DebounceRst    = 16'd30;
  localparam logic [15:0] ClickWindowRst = 16'd400;
  localparam logic [15:0] LongPressRst   = 16'd800;
  localparam logic [15:0] ResetWarnRst   = 16'd8000;
  localparam logic [15:0] ResetFireRst   = 16'd10000;
  localparam logic [15:0] RampStartRst   = 16'd1200;
  localparam logic [15:0] RampStepRst    = 16'd50;
  localparam logic [15:0] RampSweepRst   = 16'd2000;

  localparam logic [2:0]  ClickMax = 3'd7;
  localparam logic [23:0] RateMax  = 24'hFFFFFF;

  typedef enum logic [3:0] {
    CFG_DEBOUNCE     = 4'd0,
    CFG_CLICK_WINDOW = 4'd1,
    CFG_LONG_PRESS   = 4'd2,
    CFG_RESET_WARN   = 4'd3,
    CFG_RESET_FIRE   = 4'd4,
    CFG_RAMP_START   = 4'd5,
    CFG_RAMP_STEP    = 4'd6,
    CFG_RAMP_SWEEP   = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    G_NONE          = 4'd0,
    G_SINGLE        = 4'd1,
    G_DOUBLE        = 4'd2,
    G_TRIPLE        = 4'd3,
    G_QUAD          = 4'd4,
    G_LONG_START    = 4'd5,
    G_HOLD          = 4'd6,
    G_LONG_RELEASE  = 4'd7,
    G_FACTORY_RESET = 4'd8
  } gesture_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EVAL = 2'd1,
    S_MUL  = 2'd2,
    S_ACC  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] click_window;
    logic [15:0] long_press;
    logic [15:0] reset_warn;
    logic [15:0] reset_fire;
    logic [15:0] ramp_start;
    logic [15:0] ramp_step;
    logic [15:0] ramp_sweep;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now;
    logic        take;
    ev_kind_e    kind;
  } poll_t;

  typedef struct packed {
    gesture_e           gesture;
    logic [31:0]        last_hold_ms;
    logic [31:0]        hold_ms;
    logic               reset_warning;
    logic               ramp_active;
    logic signed [15:0] ramp_delta;
  } result_t;

endpackage

>>> hdl/bgc_front.sv
// front end: accepts polls, debounces the raw level, tags press and release edges
// depends on bgc_pkg
module bgc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [31:0]   now_i,
  input  logic          raw_i,
  input  logic          take_i,
  input  logic [15:0]   debounce_i,
  input  logic          q_full_i,
  input  logic          rate_busy_i,
  output logic          push_o,
  output bgc_pkg::poll_t entry_o
);

  logic        last_raw_q, last_raw_d;
  logic [31:0] change_q, change_d;
  logic        stable_q, stable_d;
  logic        edge_det;

  assign ready_o = !q_full_i && !rate_busy_i;
  assign push_o  = valid_i && ready_o;

  always_comb begin
    last_raw_d = last_raw_q;
    change_d   = change_q;
    stable_d   = stable_q;
    edge_det   = 1'b0;
    if (raw_i != last_raw_q) begin
      last_raw_d = raw_i;
      change_d   = now_i;
    end
    if ((now_i - change_d) >= {16'd0, debounce_i} && raw_i != stable_q) begin
      stable_d = raw_i;
      edge_det = 1'b1;
    end
  end

  always_comb begin
    entry_o.now  = now_i;
    entry_o.take = take_i;
    if (edge_det && raw_i) begin
      entry_o.kind = bgc_pkg::EV_PRESS;
    end else if (edge_det) begin
      entry_o.kind = bgc_pkg::EV_RELEASE;
    end else begin
      entry_o.kind = bgc_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      change_q   <= '0;
      stable_q   <= 1'b0;
    end else if (push_o) begin
      last_raw_q <= last_raw_d;
      change_q   <= change_d;
      stable_q   <= stable_d;
    end
  end

endmodule

>>> hdl/bgc_queue.sv
// two-entry poll queue between front and back end
// depends on bgc_pkg
module bgc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bgc_pkg::poll_t wdata_i,
  input  logic           pop_i,
  output bgc_pkg::poll_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  bgc_pkg::poll_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> hdl/bgc_rate_div.sv
// restoring divider for the ramp rate, range << 16 over sweep, one bit a cycle
// depends on bgc_pkg
module bgc_rate_div #(
  parameter int unsigned BRIGHTNESS_RANGE = bgc_pkg::BrightnessRangeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] sweep_i,
  output logic        busy_o,
  output logic [23:0] rate_o
);

  localparam logic [31:0] Num = 32'(BRIGHTNESS_RANGE) << 16;

  logic        pend_q;
  logic [5:0]  cnt_q;
  logic [15:0] div_q;
  logic [16:0] rem_q;
  logic [31:0] quo_q;
  logic [16:0] trial;
  logic [15:0] sweep_sel;

  assign trial  = {rem_q[15:0], quo_q[31]};
  assign busy_o = pend_q || (cnt_q != 6'd0);
  assign rate_o = (|quo_q[31:24]) ? bgc_pkg::RateMax : quo_q[23:0];
  // the run after reset divides by the reset value of the sweep register
  assign sweep_sel = start_i ? sweep_i : bgc_pkg::RampSweepRst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      cnt_q  <= '0;
      div_q  <= 16'd1;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (start_i || pend_q) begin
      pend_q <= 1'b0;
      cnt_q  <= 6'd32;
      div_q  <= (sweep_sel == 16'd0) ? 16'd1 : sweep_sel;
      rem_q  <= '0;
      quo_q  <= Num;
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
      if (trial >= {1'b0, div_q}) begin
        rem_q <= trial - {1'b0, div_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/bgc_back.sv
// back end: gesture state machine, click counting, hold timers and ramp accumulator
// depends on bgc_pkg and the assertion macro header
`include "button_gesture_classifier_top_defines.svh"
module bgc_back #(
  parameter int unsigned QUAD_CLICKS = bgc_pkg::QuadClicksDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bgc_pkg::cfg_t    cfg_i,
  input  logic [23:0]      rate_i,
  input  logic             q_empty_i,
  input  bgc_pkg::poll_t   q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bgc_pkg::result_t out_o
);

  localparam logic [2:0] Quad = 3'(QUAD_CLICKS);

  bgc_pkg::back_state_e state_q, state_d;
  bgc_pkg::poll_t       cur_q;

  logic        held_q, held_d;
  logic [31:0] press_start_q, press_start_d;
  logic        long_q, long_d;
  logic        rfired_q, rfired_d;
  logic [31:0] last_ev_q, last_ev_d;
  logic [2:0]  clicks_q, clicks_d;
  logic [31:0] deadline_q, deadline_d;
  logic        down_q, down_d;
  logic        started_q, started_d;
  logic [31:0] phase_q, phase_d;
  logic [31:0] last_upd_q, last_upd_d;
  logic signed [31:0] accum_q, accum_d;
  logic [31:0] prev_q, prev_d;

  bgc_pkg::gesture_e gest_q, gest_d;
  logic [31:0] dur_q, dur_d;
  logic        warn_q, warn_d;
  logic        ramp_q, ramp_d;
  logic        acc_en_q, acc_en_d;
  logic        acc_dn_q, acc_dn_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [55:0] prod_q;

  bgc_pkg::result_t out_q;
  logic             out_valid_q;
  logic             out_load;

  logic [31:0] now, hold_dur, sweep_eff, since_due;
  logic [2:0]  cnt_inc;
  logic signed [57:0] sum;
  logic signed [31:0] acc_sat;
  logic signed [15:0] whole;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bgc_pkg::S_IDLE: if (!q_empty_i) state_d = bgc_pkg::S_EVAL;
      bgc_pkg::S_EVAL: state_d = bgc_pkg::S_MUL;
      bgc_pkg::S_MUL:  state_d = bgc_pkg::S_ACC;
      bgc_pkg::S_ACC:  if (!out_valid_q || out_ready_i) state_d = bgc_pkg::S_IDLE;
      default:         state_d = bgc_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      bgc_pkg::S_IDLE: pop_o = !q_empty_i;
      bgc_pkg::S_ACC:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // per-poll state update
  always_comb begin
    held_d = held_q; press_start_d = press_start_q; long_d = long_q;
    rfired_d = rfired_q; last_ev_d = last_ev_q; clicks_d = clicks_q;
    deadline_d = deadline_q; down_d = down_q; started_d = started_q;
    phase_d = phase_q; last_upd_d = last_upd_q; prev_d = prev_q;
    gest_d = gest_q; dur_d = dur_q; warn_d = warn_q; ramp_d = ramp_q;
    acc_en_d = acc_en_q; acc_dn_d = acc_dn_q; elapsed_d = elapsed_q;
    now       = cur_q.now;
    hold_dur  = now - press_start_q;
    since_due = now - deadline_q;
    sweep_eff = (cfg_i.ramp_sweep == 16'd0) ? 32'd1 : {16'd0, cfg_i.ramp_sweep};
    cnt_inc   = (clicks_q == bgc_pkg::ClickMax) ? bgc_pkg::ClickMax : clicks_q + 3'd1;
    if (state_q == bgc_pkg::S_EVAL) begin
      gest_d    = bgc_pkg::G_NONE;
      acc_en_d  = 1'b0;
      acc_dn_d  = down_q;
      elapsed_d = now - last_upd_q;
      case (cur_q.kind)
        bgc_pkg::EV_PRESS: begin
          held_d = 1'b1; press_start_d = now; long_d = 1'b0;
          rfired_d = 1'b0; last_ev_d = now;
        end
        bgc_pkg::EV_RELEASE: begin
          prev_d = hold_dur;
          held_d = 1'b0;
          if (rfired_q || long_q) begin
            press_start_d = '0; long_d = 1'b0; rfired_d = 1'b0; last_ev_d = '0;
            down_d = 1'b0; started_d = 1'b0; phase_d = '0; last_upd_d = '0;
            gest_d = bgc_pkg::G_LONG_RELEASE;
          end else begin
            deadline_d = now + {16'd0, cfg_i.click_window};
            if (cnt_inc >= Quad) begin
              clicks_d = '0;
              gest_d   = bgc_pkg::G_QUAD;
            end else begin
              clicks_d = cnt_inc;
            end
          end
        end
        default: begin
          if (held_q) begin
            if (!rfired_q && hold_dur >= {16'd0, cfg_i.reset_fire}) begin
              rfired_d = 1'b1; clicks_d = '0;
              gest_d = bgc_pkg::G_FACTORY_RESET;
            end else if (!rfired_q && hold_dur >= {16'd0, cfg_i.long_press}) begin
              if (!long_q) begin
                long_d = 1'b1; clicks_d = '0; last_ev_d = now;
                gest_d = bgc_pkg::G_LONG_START;
              end else begin
                if (hold_dur >= {16'd0, cfg_i.ramp_start}) begin
                  if (!started_q) begin
                    // first ramp poll only arms the timers
                    started_d = 1'b1; down_d = 1'b0; phase_d = now; last_upd_d = now;
                  end else begin
                    acc_en_d   = 1'b1;
                    last_upd_d = now;
                    if ((now - phase_q) >= sweep_eff) begin
                      down_d  = !down_q;
                      phase_d = now;
                    end
                  end
                end
                if ((now - last_ev_q) >= {16'd0, cfg_i.ramp_step}) begin
                  last_ev_d = now;
                  gest_d = bgc_pkg::G_HOLD;
                end
              end
            end
          end else if (clicks_q != 3'd0 && !since_due[31]) begin
            clicks_d = '0;
            case (clicks_q)
              3'd1:    gest_d = bgc_pkg::G_SINGLE;
              3'd2:    gest_d = bgc_pkg::G_DOUBLE;
              3'd3:    gest_d = bgc_pkg::G_TRIPLE;
              default: gest_d = bgc_pkg::G_NONE;
            endcase
          end
        end
      endcase
      dur_d  = held_d ? now - press_start_d : 32'd0;
      warn_d = held_d && !rfired_d && dur_d >= {16'd0, cfg_i.reset_warn};
      ramp_d = held_d && !rfired_d && long_d && dur_d >= {16'd0, cfg_i.ramp_start};
    end
  end

  // accumulate with saturation, then on a take poll with the ramp active take the whole part toward zero
  always_comb begin
    if (acc_dn_q) begin
      sum = 58'(accum_q) - $signed({2'b00, prod_q});
    end else begin
      sum = 58'(accum_q) + $signed({2'b00, prod_q});
    end
    if (sum > 58'sh7FFFFFFF) begin
      acc_sat = 32'sh7FFFFFFF;
    end else if (sum < -58'sh80000000) begin
      acc_sat = -32'sh80000000;
    end else begin
      acc_sat = sum[31:0];
    end
    whole   = '0;
    accum_d = acc_sat;
    if (cur_q.take && ramp_q) begin
      whole = acc_sat[31:16] + 16'((acc_sat[31] && (acc_sat[15:0] != 16'd0)) ? 1 : 0);
      accum_d = acc_sat - {whole, 16'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_data_i;
    if (state_q == bgc_pkg::S_MUL) begin
      prod_q <= acc_en_q ? 56'(rate_i) * 56'(elapsed_q) : 56'd0;
    end
    if (out_load) begin
      out_q.gesture       <= gest_q;
      out_q.last_hold_ms  <= prev_q;
      out_q.hold_ms       <= dur_q;
      out_q.reset_warning <= warn_q;
      out_q.ramp_active   <= ramp_q;
      out_q.ramp_delta    <= whole;
    end
    gest_d_reg: begin
      gest_q <= gest_d; dur_q <= dur_d; warn_q <= warn_d; ramp_q <= ramp_d;
      acc_en_q <= acc_en_d; acc_dn_q <= acc_dn_d; elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgc_pkg::S_IDLE;
      held_q <= 1'b0; press_start_q <= '0; long_q <= 1'b0; rfired_q <= 1'b0;
      last_ev_q <= '0; clicks_q <= '0; deadline_q <= '0; down_q <= 1'b0;
      started_q <= 1'b0; phase_q <= '0; last_upd_q <= '0; accum_q <= '0;
      prev_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q <= held_d; press_start_q <= press_start_d; long_q <= long_d;
      rfired_q <= rfired_d; last_ev_q <= last_ev_d; clicks_q <= clicks_d;
      deadline_q <= deadline_d; down_q <= down_d; started_q <= started_d;
      phase_q <= phase_d; last_upd_q <= last_upd_d; prev_q <= prev_d;
      if (state_q == bgc_pkg::S_EVAL && cur_q.kind == bgc_pkg::EV_RELEASE
          && (rfired_q || long_q)) begin
        accum_q <= '0;
      end else if (out_load) begin
        accum_q <= accum_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BGC_ASSERT(a_mul_to_acc, state_q == bgc_pkg::S_MUL |=> state_q == bgc_pkg::S_ACC, "mul not followed by acc")
  `BGC_ASSERT(a_release_clears, !held_q |-> !long_q && !rfired_q, "hold flags set while released")
  `BGC_ASSERT(a_click_bound, clicks_q < Quad, "click count reached quad")
  `BGC_ASSERT(a_ramp_needs_long, started_q |-> long_q, "ramp armed without long press")

endmodule

>>> hdl/button_gesture_classifier_top.sv
// Button gesture classifier. Polls come in on the s_axis channel, one beat per
// poll (now_ms, raw level, take_delta); one result beat per poll leaves on m_axis
// (gesture, last and current hold time, reset warning, ramp flag, ramp delta).
// Thresholds are set through the cfg write channel (index 0..7, 16-bit data,
// other indexes ignored); write them only while no poll is in flight.
// The front end debounces and tags edges in the accept cycle and pushes into a
// two-entry queue; the back end steps through four states per poll (pop,
// evaluate, 24x32 ramp multiply, accumulate) and pops no new poll before the
// accumulate state has loaded its result into the output register.
// After reset and after each write of the sweep register a divider computes
// the ramp rate; s_axis_tready_o stays low until it is done.
// A stalled m_axis holds its result in the output register; the back end
// waits, the queue fills and then s_axis_tready_o drops.
// depends on bgc_pkg, bgc_front, bgc_queue, bgc_rate_div, bgc_back
module button_gesture_classifier_top #(
  parameter int unsigned BRIGHTNESS_RANGE = bgc_pkg::BrightnessRangeDef,
  parameter int unsigned QUAD_CLICKS      = bgc_pkg::QuadClicksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // now_ms[31:0], raw_pressed[32], take_delta[33], zero pad
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // gesture[3:0], last_hold_ms[35:4], hold_ms[67:36], reset_warning[68],
  // ramp_active[69], ramp_delta[85:70], zero pad
  output logic [87:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  bgc_pkg::cfg_t    cfg_q;
  bgc_pkg::poll_t   push_entry, q_rdata;
  bgc_pkg::result_t res;
  logic        push, pop, q_full, q_empty, rate_busy, sweep_wr;
  logic [23:0] rate;

  assign cfg_ready_o = 1'b1;
  assign sweep_wr = cfg_valid_i && (cfg_addr_i == bgc_pkg::CFG_RAMP_SWEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce     <= bgc_pkg::DebounceRst;
      cfg_q.click_window <= bgc_pkg::ClickWindowRst;
      cfg_q.long_press   <= bgc_pkg::LongPressRst;
      cfg_q.reset_warn   <= bgc_pkg::ResetWarnRst;
      cfg_q.reset_fire   <= bgc_pkg::ResetFireRst;
      cfg_q.ramp_start   <= bgc_pkg::RampStartRst;
      cfg_q.ramp_step    <= bgc_pkg::RampStepRst;
      cfg_q.ramp_sweep   <= bgc_pkg::RampSweepRst;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        bgc_pkg::CFG_DEBOUNCE:     cfg_q.debounce     <= cfg_data_i;
        bgc_pkg::CFG_CLICK_WINDOW: cfg_q.click_window <= cfg_data_i;
        bgc_pkg::CFG_LONG_PRESS:   cfg_q.long_press   <= cfg_data_i;
        bgc_pkg::CFG_RESET_WARN:   cfg_q.reset_warn   <= cfg_data_i;
        bgc_pkg::CFG_RESET_FIRE:   cfg_q.reset_fire   <= cfg_data_i;
        bgc_pkg::CFG_RAMP_START:   cfg_q.ramp_start   <= cfg_data_i;
        bgc_pkg::CFG_RAMP_STEP:    cfg_q.ramp_step    <= cfg_data_i;
        bgc_pkg::CFG_RAMP_SWEEP:   cfg_q.ramp_sweep   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bgc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .now_i       (s_axis_tdata_i[31:0]),
    .raw_i       (s_axis_tdata_i[32]),
    .take_i      (s_axis_tdata_i[33]),
    .debounce_i  (cfg_q.debounce),
    .q_full_i    (q_full),
    .rate_busy_i (rate_busy),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  bgc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bgc_rate_div #(
    .BRIGHTNESS_RANGE (BRIGHTNESS_RANGE)
  ) u_rate_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sweep_wr),
    .sweep_i (cfg_data_i),
    .busy_o  (rate_busy),
    .rate_o  (rate)
  );

  bgc_back #(
    .QUAD_CLICKS (QUAD_CLICKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rate_i      (rate),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {2'b00, res.ramp_delta, res.ramp_active, res.reset_warning,
                           res.hold_ms, res.last_hold_ms, res.gesture};

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for button_gesture_classifier_top: random polls with
// press, click and long hold scripts, checked beat by beat against a local model
// depends on bgc_pkg and the button_gesture_classifier_top rtl
module testbench;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 20;
  localparam logic [3:0] CfgIdxUnused = 4'd11;

  typedef struct {
    logic [31:0] now;
    bit          raw;
    bit          take;
  } poll_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [87:0] m_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  button_gesture_classifier_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  poll_item_t          poll_q[$];
  bgc_pkg::result_t    gesture_q[$];
  int unsigned polls_made = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          quiet = 1'b0;
  bit          poll_fired = 1'b0;
  logic [31:0] t_now = '0;

  // classifier model state
  logic [15:0] reg_val[8] = '{bgc_pkg::DebounceRst, bgc_pkg::ClickWindowRst,
                              bgc_pkg::LongPressRst, bgc_pkg::ResetWarnRst,
                              bgc_pkg::ResetFireRst, bgc_pkg::RampStartRst,
                              bgc_pkg::RampStepRst, bgc_pkg::RampSweepRst};
  bit          lvl_last = 0, deb_pressed = 0, btn_held = 0, long_on = 0, fr_on = 0;
  bit          sweep_dn = 0, sweep_on = 0;
  logic [31:0] lvl_change_t = 0, press_t0 = 0, hold_evt_t = 0, click_due = 0;
  logic [31:0] sweep_t0 = 0, sweep_upd_t = 0, prev_dur = 0;
  int unsigned clicks = 0;
  int          accum = 0;

  task automatic classify_poll(input logic [31:0] now, input bit raw, input bit take);
    bit                 was, flip;
    bgc_pkg::gesture_e  g;
    logic [31:0]        dur, sweep, rate, elapsed, since_due;
    longint             stp, sum;
    int                 w;
    bgc_pkg::result_t   r;
    was = deb_pressed;
    flip = 0;
    g = bgc_pkg::G_NONE;
    w = 0;
    if (raw != lvl_last) begin
      lvl_last = raw;
      lvl_change_t = now;
    end
    if (now - lvl_change_t >= {16'd0, reg_val[bgc_pkg::CFG_DEBOUNCE]}
        && raw != deb_pressed) begin
      deb_pressed = raw;
      flip = 1;
    end
    if (flip && deb_pressed && !was) begin
      btn_held = 1;
      press_t0 = now;
      long_on = 0;
      fr_on = 0;
      hold_evt_t = now;
    end else if (flip && !deb_pressed && was) begin
      prev_dur = now - press_t0;
      btn_held = 0;
      if (fr_on || long_on) begin
        press_t0 = 0; long_on = 0; fr_on = 0; hold_evt_t = 0;
        sweep_dn = 0; sweep_on = 0; sweep_t0 = 0; sweep_upd_t = 0; accum = 0;
        g = bgc_pkg::G_LONG_RELEASE;
      end else begin
        if (clicks < bgc_pkg::ClickMax) clicks++;
        click_due = now + {16'd0, reg_val[bgc_pkg::CFG_CLICK_WINDOW]};
        if (clicks >= bgc_pkg::QuadClicksDef) begin
          clicks = 0;
          g = bgc_pkg::G_QUAD;
        end
      end
    end else if (btn_held) begin
      dur = now - press_t0;
      if (!fr_on && dur >= {16'd0, reg_val[bgc_pkg::CFG_RESET_FIRE]}) begin
        fr_on = 1;
        clicks = 0;
        g = bgc_pkg::G_FACTORY_RESET;
      end else if (!fr_on && dur >= {16'd0, reg_val[bgc_pkg::CFG_LONG_PRESS]}) begin
        if (!long_on) begin
          long_on = 1;
          clicks = 0;
          hold_evt_t = now;
          g = bgc_pkg::G_LONG_START;
        end else begin
          if (dur >= {16'd0, reg_val[bgc_pkg::CFG_RAMP_START]}) begin
            sweep = (reg_val[bgc_pkg::CFG_RAMP_SWEEP] == 0) ? 32'd1
                    : {16'd0, reg_val[bgc_pkg::CFG_RAMP_SWEEP]};
            if (!sweep_on) begin
              // first ramp poll only arms the timers
              sweep_on = 1;
              sweep_dn = 0;
              sweep_t0 = now;
              sweep_upd_t = now;
            end else begin
              elapsed = now - sweep_upd_t;
              sweep_upd_t = now;
              rate = (bgc_pkg::BrightnessRangeDef << 16) / sweep;
              if (rate > {8'd0, bgc_pkg::RateMax}) rate = {8'd0, bgc_pkg::RateMax};
              stp = longint'(rate) * longint'(elapsed);
              sum = sweep_dn ? longint'(accum) - stp : longint'(accum) + stp;
              if (sum > 64'sd2147483647) sum = 64'sd2147483647;
              if (sum < -64'sd2147483648) sum = -64'sd2147483648;
              accum = int'(sum);
              if (now - sweep_t0 >= sweep) begin
                sweep_dn = !sweep_dn;
                sweep_t0 = now;
              end
            end
          end
          if (now - hold_evt_t >= {16'd0, reg_val[bgc_pkg::CFG_RAMP_STEP]}) begin
            hold_evt_t = now;
            g = bgc_pkg::G_HOLD;
          end
        end
      end
    end else if (clicks != 0) begin
      since_due = now - click_due;
      // window over once the deadline is not in the future
      if (!since_due[31]) begin
        case (clicks)
          1: g = bgc_pkg::G_SINGLE;
          2: g = bgc_pkg::G_DOUBLE;
          3: g = bgc_pkg::G_TRIPLE;
          default: g = bgc_pkg::G_NONE;
        endcase
        clicks = 0;
      end
    end
    dur = btn_held ? now - press_t0 : 32'd0;
    r.gesture = g;
    r.last_hold_ms = prev_dur;
    r.hold_ms = dur;
    r.reset_warning = btn_held && !fr_on
                      && dur >= {16'd0, reg_val[bgc_pkg::CFG_RESET_WARN]};
    r.ramp_active = btn_held && !fr_on && long_on
                    && dur >= {16'd0, reg_val[bgc_pkg::CFG_RAMP_START]};
    if (take && r.ramp_active) begin
      w = accum / 65536;
      accum = accum - w * 65536;
    end
    r.ramp_delta = w[15:0];
    gesture_q.push_back(r);
  endtask

  // sender
  always @(negedge clk_i) begin
    poll_item_t p;
    if (rst_ni && (!s_valid || poll_fired)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_valid <= 1'b0;
      end else if (poll_q.size() > 0 && !quiet && $urandom_range(0, 19) == 0) begin
        in_gap = $urandom_range(1, 15);
        s_valid <= 1'b0;
      end else if (poll_q.size() > 0) begin
        p = poll_q.pop_front();
        s_valid <= 1'b1;
        s_data <= {6'd0, p.take, p.raw, p.now};
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      m_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(1, 15);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    bgc_pkg::result_t e, a;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    poll_fired <= s_valid && s_ready;
    if (rst_ni && s_valid && s_ready)
      classify_poll(s_data[31:0], s_data[32], s_data[33]);
    if (rst_ni && m_valid && m_ready) begin
      a.gesture = bgc_pkg::gesture_e'(m_data[3:0]);
      a.last_hold_ms = m_data[35:4];
      a.hold_ms = m_data[67:36];
      a.reset_warning = m_data[68];
      a.ramp_active = m_data[69];
      a.ramp_delta = m_data[85:70];
      if (gesture_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", m_data);
      end else begin
        e = gesture_q.pop_front();
        if (a.gesture !== e.gesture || a.last_hold_ms !== e.last_hold_ms ||
            a.hold_ms !== e.hold_ms || a.reset_warning !== e.reset_warning ||
            a.ramp_active !== e.ramp_active || a.ramp_delta !== e.ramp_delta) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp g=%0d last=%0d hold=%0d warn=%b ramp=%b d=%0d",
                      " | got g=%0d last=%0d hold=%0d warn=%b ramp=%b d=%0d"},
                     e.gesture, e.last_hold_ms, e.hold_ms, e.reset_warning, e.ramp_active,
                     e.ramp_delta, a.gesture, a.last_hold_ms, a.hold_ms, a.reset_warning,
                     a.ramp_active, a.ramp_delta);
        end
      end
    end
  end

  task automatic push_poll(input bit raw, input bit take);
    poll_item_t p;
    p.now = t_now;
    p.raw = raw;
    p.take = take;
    poll_q.push_back(p);
    polls_made++;
  endtask

  task automatic add_press(input int unsigned hold, input int unsigned step_max,
                           input bit bounce);
    logic [31:0] t0;
    if (bounce) begin
      repeat ($urandom_range(1, 3)) begin
        t_now += $urandom_range(0, 2);
        push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    t_now += $urandom_range(1, step_max);
    t0 = t_now;
    push_poll(1'b1, 1'($urandom_range(0, 1)));
    while (t_now - t0 < hold) begin
      t_now += $urandom_range(1, step_max);
      push_poll(1'b1, 1'($urandom_range(0, 1)));
    end
    if (bounce) begin
      t_now += $urandom_range(0, 2);
      push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    t_now += $urandom_range(1, step_max);
    push_poll(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned step_max,
                           input int unsigned hold_max);
    int unsigned target;
    target = polls_made + n;
    while (polls_made < target) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary level, sometimes a large time jump
        if ($urandom_range(0, 3) == 0) t_now = $urandom;
        else t_now += $urandom_range(0, step_max);
        push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        add_press($urandom_range(0, 1) ? $urandom_range(0, hold_max / 10)
                                        : $urandom_range(0, hold_max),
                  step_max, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 2) == 0) t_now += $urandom_range(step_max, 40 * step_max);
          else t_now += $urandom_range(1, step_max);
          push_poll(1'b0, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic settle();
    while (poll_q.size() != 0 || s_valid || gesture_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx <= bgc_pkg::CFG_RAMP_SWEEP) reg_val[idx[2:0]] = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] v0, v1, v2, v3, v4, v5, v6, v7);
    write_reg(bgc_pkg::CFG_DEBOUNCE, v0);
    write_reg(bgc_pkg::CFG_CLICK_WINDOW, v1);
    write_reg(bgc_pkg::CFG_LONG_PRESS, v2);
    write_reg(bgc_pkg::CFG_RESET_WARN, v3);
    write_reg(bgc_pkg::CFG_RESET_FIRE, v4);
    write_reg(bgc_pkg::CFG_RAMP_START, v5);
    write_reg(bgc_pkg::CFG_RAMP_STEP, v6);
    write_reg(bgc_pkg::CFG_RAMP_SWEEP, v7);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: one to four clicks with no debounce, each followed by window expiry, then a long hold
    write_all(16'd0, 16'd20, 16'd60, 16'd150, 16'd250, 16'd80, 16'd7, 16'd37);
    t_now = 32'hFFFF_FFC0;
    for (int k = 1; k <= 4; k++) begin
      repeat (k) add_press(0, 1, 1'b0);
      t_now += 32'd25;
      push_poll(1'b0, 1'b1);
    end
    add_press(300, 9, 1'b0);
    settle();

    // reset values restored, long steps so full holds stay short
    write_all(bgc_pkg::DebounceRst, bgc_pkg::ClickWindowRst, bgc_pkg::LongPressRst,
              bgc_pkg::ResetWarnRst, bgc_pkg::ResetFireRst, bgc_pkg::RampStartRst,
              bgc_pkg::RampStepRst, bgc_pkg::RampSweepRst);
    t_now = $urandom;
    run_phase(200, 300, 12000);
    settle();

    write_all(16'd3, 16'd40, 16'd60, 16'd150, 16'd250, 16'd80, 16'd7, 16'd37);
    run_phase(400, 12, 300);
    settle();

    // all zero: sweep treated as one, factory reset on the first held poll
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(CfgIdxUnused, 16'hFFFF);
    run_phase(150, 5, 50);
    settle();

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    t_now = $urandom;
    run_phase(150, 8000, 140000);
    settle();

    write_all(16'($urandom_range(0, 6)), 16'($urandom_range(5, 80)),
              16'($urandom_range(10, 90)), 16'($urandom_range(50, 300)),
              16'($urandom_range(100, 400)), 16'($urandom_range(20, 200)),
              16'($urandom_range(1, 20)), 16'($urandom_range(1, 120)));
    quiet = 1'b1;
    run_phase(200, 20, 400);
    settle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
